// ===== src/wmf_pkg.sv =====
// Shared types and constants of the window median filter.
// Item structs, register map, reset values and output queue sizing.
// No dependencies.
package wmf_pkg;

    localparam int PIX_W            = 8;
    localparam int CFG_W            = 12;
    localparam int DEF_WINDOW       = 3;
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;

    localparam logic [PIX_W-1:0] BORDER_VALUE = PIX_W'(255);

    // APB register map: one 32-bit word per register
    localparam int APB_DATA_W = 32;
    localparam int ADDR_LSB   = 2;
    localparam int REG_IDX_W  = 1;
    localparam int APB_ADDR_W = ADDR_LSB + REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;

    // output queue, power of two
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             frame_end;
    } t_out_item;

endpackage

// ===== src/wmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read of the address being written returns the old contents.
// No dependencies.
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/wmf_median.sv =====
// Median of a square neighborhood by parallel rank counting.
// Ties are ranked by position, so exactly one tap holds the middle rank.
// Depends on wmf_pkg.
module wmf_median #(
    parameter int TAPS = 9
) (
    input  logic [TAPS*wmf_pkg::PIX_W-1:0] i_window,
    output logic [wmf_pkg::PIX_W-1:0]      o_median
);
    import wmf_pkg::*;

    localparam int MID = TAPS / 2;

    logic [PIX_W-1:0] pix [TAPS];
    logic [TAPS-1:0]  below [TAPS];
    logic [TAPS-1:0]  is_mid;

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            pix[i] = i_window[i*PIX_W +: PIX_W];
        end
    end

    // below[i][j]: tap j ranks ahead of tap i
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
                if (j < i) begin
                    below[i][j] = (pix[j] <= pix[i]);
                end else begin
                    below[i][j] = (pix[j] < pix[i]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            is_mid[i] = ($countones(below[i]) == MID);
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < TAPS; i++) begin
            o_median = o_median | ({PIX_W{is_mid[i]}} & pix[i]);
        end
    end

endmodule

// ===== src/window_median_filter_top.sv =====
// Streaming WINDOW x WINDOW median filter for 8-bit grey frames, APB config.
// A result passes the stage 1 and stage 2 registers and the output queue before o_out_valid offers it.
// Throughput: one item per cycle, with one line RAM read per item and write per pixel,
// as long as the 4-entry output queue is drained; it throttles o_in_ready otherwise.
// Reset: counters, pipeline and queue cleared, size back to 640x480;
// the line RAM is not cleared and needs no clearing pass.
module window_median_filter_top #(
    parameter int WINDOW    = wmf_pkg::DEF_WINDOW,
    parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  wmf_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output wmf_pkg::t_out_item               o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wmf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wmf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wmf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import wmf_pkg::*;

    localparam int HALF      = WINDOW / 2;
    localparam int SPAN      = 2 * HALF + 1;
    localparam int TAPS      = SPAN * SPAN;
    localparam int ABOVE     = SPAN - 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW        = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = CFG_W;
    localparam int CNT_W     = EW + CFG_W;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
    localparam int EFF_W_RST = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int TOTAL_RST = EFF_W_RST * RST_IMAGE_HEIGHT;
    localparam int LAG_RST   = HALF * EFF_W_RST + HALF;

    function automatic logic [EW-1:0] f_eff_w(input logic [CFG_W-1:0] v);
        logic [EW-1:0] res;
        if (v == '0) begin
            res = EW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            res = EW'(MAX_WIDTH);
        end else begin
            res = EW'(v);
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    logic [CFG_W-1:0]     r_width, r_height, n_width, n_height;
    logic [EW-1:0]        r_eff_w, n_eff_w;
    logic [CFG_W-1:0]     r_eff_h, n_eff_h;
    logic [CNT_W-1:0]     r_total_m1, n_total_m1;
    logic [CNT_W-1:0]     r_lag, n_lag;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_LSB +: REG_IDX_W];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  n_width  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: n_height = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
        n_eff_w    = f_eff_w(n_width);
        n_eff_h    = (n_height == '0) ? CFG_W'(1) : n_height;
        n_total_m1 = CNT_W'(n_eff_w) * CNT_W'(n_eff_h) - CNT_W'(1);
        n_lag      = CNT_W'(HALF) * CNT_W'(n_eff_w) + CNT_W'(HALF);
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_W'(RST_IMAGE_WIDTH);
            r_height   <= CFG_W'(RST_IMAGE_HEIGHT);
            r_eff_w    <= EW'(EFF_W_RST);
            r_eff_h    <= CFG_W'(RST_IMAGE_HEIGHT);
            r_total_m1 <= CNT_W'(TOTAL_RST - 1);
            r_lag      <= CNT_W'(LAG_RST);
        end else if (cfg_wr) begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_eff_w    <= n_eff_w;
            r_eff_h    <= n_eff_h;
            r_total_m1 <= n_total_m1;
            r_lag      <= n_lag;
        end
    end

    // ---------------- raster counters ----------------
    logic             acc, wr, emit, out_last, border;
    logic             in_col_wrap, in_row_last, in_done_now, out_col_wrap;
    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [CNT_W-1:0] r_in_cnt, r_out_cnt, r_out_lag;
    logic             r_in_done;

    assign acc         = i_in_valid & o_in_ready;
    assign wr          = acc & (i_in_item.operation == OP_PIXEL) & ~r_in_done;
    assign in_col_wrap = (32'(r_in_col) + 1) >= 32'(r_eff_w);
    assign in_row_last = (32'(r_in_row) + 1) >= 32'(r_eff_h);
    assign in_done_now = r_in_done | (wr & in_col_wrap & in_row_last);
    // r_out_lag tracks output position plus lag
    assign emit = acc & (in_done_now | (wr ? (r_out_lag <= r_in_cnt) : (r_out_lag < r_in_cnt)));
    assign out_last     = (r_out_cnt == r_total_m1);
    assign out_col_wrap = (32'(r_out_col) + 1) >= 32'(r_eff_w);
    assign border = (32'(r_out_row) < HALF) || ((32'(r_out_row) + HALF) >= 32'(r_eff_h)) ||
                    (32'(r_out_col) < HALF) || ((32'(r_out_col) + HALF) >= 32'(r_eff_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_cnt  <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_cnt <= '0;
            r_out_lag <= CNT_W'(LAG_RST);
        end else if (cfg_wr || (emit && out_last)) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_cnt  <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_cnt <= '0;
            r_out_lag <= n_lag;
        end else begin
            if (wr) begin
                r_in_cnt <= r_in_cnt + CNT_W'(1);
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    if (in_row_last) begin
                        r_in_done <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + ROW_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (emit) begin
                r_out_cnt <= r_out_cnt + CNT_W'(1);
                r_out_lag <= r_out_lag + CNT_W'(1);
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    // ---------------- stage 1: line RAM and column ----------------
    logic                     r_s1_wr, r_s1_emit, r_s1_border, r_s1_last;
    logic [PIX_W-1:0]         r_s1_pix;
    logic [COL_W-1:0]         r_s1_col;
    logic                     r_fwd;
    logic [ABOVE*PIX_W-1:0]   r_fwd_data;
    logic [ABOVE*PIX_W-1:0]   ram_rdata, above, line_wdata;
    logic [SPAN*PIX_W-1:0]    col_vec;

    wmf_ram #(
        .WIDTH (ABOVE * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (line_wdata),
        .i_rd_en   (acc),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_rdata)
    );

    // forward when the previous item wrote this column at the read edge
    assign above      = r_fwd ? r_fwd_data : ram_rdata;
    assign col_vec    = {above, r_s1_pix};
    assign line_wdata = col_vec[ABOVE*PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_wr   <= 1'b0;
            r_s1_emit <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_s1_wr   <= wr;
            r_s1_emit <= emit;
            r_fwd     <= r_s1_wr && (r_s1_col == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix    <= i_in_item.pixel;
        r_s1_col    <= r_in_col;
        r_s1_border <= border;
        r_s1_last   <= out_last;
        r_fwd_data  <= line_wdata;
    end

    // ---------------- stage 2: window and median ----------------
    logic [TAPS*PIX_W-1:0] r_win;
    logic                  r_s2_emit, r_s2_border, r_s2_last;
    logic [PIX_W-1:0]      median;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_s2_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_s1_emit;
            if (r_s1_wr) begin
                r_win <= {col_vec, r_win[TAPS*PIX_W-1:SPAN*PIX_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_border <= r_s1_border;
        r_s2_last   <= r_s1_last;
    end

    wmf_median #(
        .TAPS (TAPS)
    ) u_median (
        .i_window (r_win),
        .o_median (median)
    );

    // ---------------- output queue ----------------
    t_out_item               r_oq [OQ_DEPTH];
    t_out_item               oq_item;
    logic [OQ_PTR_W-1:0]     r_oq_wr_ptr, r_oq_rd_ptr;
    logic [OQ_CNT_W-1:0]     r_oq_cnt;
    logic [OQ_CNT_W:0]       oq_credit;
    logic                    oq_push, oq_pop;

    assign oq_push           = r_s2_emit;
    assign oq_pop            = o_out_valid & i_out_ready;
    assign oq_item.out_pixel = r_s2_border ? BORDER_VALUE : median;
    assign oq_item.frame_end = r_s2_last;

    // items in flight hold a queue slot
    assign oq_credit  = (OQ_CNT_W + 1)'(r_oq_cnt) + (OQ_CNT_W + 1)'(r_s1_emit)
                      + (OQ_CNT_W + 1)'(r_s2_emit);
    assign o_in_ready = (oq_credit < (OQ_CNT_W + 1)'(OQ_DEPTH));

    assign o_out_valid = (r_oq_cnt != '0);
    assign o_out_item  = r_oq[r_oq_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr_ptr] <= oq_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr_ptr <= '0;
            r_oq_rd_ptr <= '0;
            r_oq_cnt    <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr_ptr <= r_oq_wr_ptr + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd_ptr <= r_oq_rd_ptr + OQ_PTR_W'(1);
            end
            case ({oq_push, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(1);
                2'b01:   r_oq_cnt <= r_oq_cnt - OQ_CNT_W'(1);
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule

// ===== src/wmf_checker.sv =====
// Port-level checks of the window median filter, bound to its top level.
// Depends on wmf_pkg and window_median_filter_top.
module wmf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input wmf_pkg::t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // an empty queue refills only from an item accepted before it
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 3))
        else $error("result without matching item");

    // input is throttled only by pending results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind window_median_filter_top wmf_checker u_wmf_checker (.*);
